/* rtl/core/br2_pkg.sv */
// Shared types and constants for the radix-2 Booth multiplier.
// Used by br2_ctrl, br2_datapath and booth_radix2_multiplier; depends on nothing.
package br2_pkg;

    localparam int OPERAND_W = 32;
    localparam int PRODUCT_W = 64;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } br2_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } br2_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_step;
    } br2_status_t;

endpackage

/* rtl/core/br2_datapath.sv */
// Datapath of the radix-2 Booth multiplier: product register, Booth bit,
// held multiplicand, step counter and result register. Depends on br2_pkg.
module br2_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  br2_pkg::br2_cmd_t              cmd,
    output br2_pkg::br2_status_t           status,
    input  logic [br2_pkg::OPERAND_W-1:0]  multiplier,
    input  logic [br2_pkg::OPERAND_W-1:0]  multiplicand,
    output logic [br2_pkg::PRODUCT_W-1:0]  product
);
    import br2_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [1:0] PAIR_ADD = 2'b01;
    localparam logic [1:0] PAIR_SUB = 2'b10;

    logic [WIDTH:0]       upper_reg, upper_next;
    logic [WIDTH-1:0]     lower_reg, lower_next;
    logic                 booth_reg, booth_next;
    logic [WIDTH-1:0]     mcand_reg, mcand_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [PRODUCT_W-1:0] product_reg, product_next;

    logic [WIDTH:0]       mcand_ext;
    logic [WIDTH:0]       sum;
    logic [WIDTH:0]       step_upper;
    logic [WIDTH-1:0]     step_lower;
    logic [PRODUCT_W-1:0] product_wide;

    assign mcand_ext = {mcand_reg[WIDTH-1], mcand_reg};

    // One Booth step: add or subtract, then arithmetic shift right.
    always_comb begin
        case ({lower_reg[0], booth_reg})
            PAIR_ADD: sum = upper_reg + mcand_ext;
            PAIR_SUB: sum = upper_reg - mcand_ext;
            default:  sum = upper_reg;
        endcase
        step_upper   = {sum[WIDTH], sum[WIDTH:1]};
        step_lower   = {sum[0], lower_reg[WIDTH-1:1]};
        product_wide = PRODUCT_W'($signed({step_upper, step_lower}));
    end

    always_comb begin
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        booth_next   = booth_reg;
        mcand_next   = mcand_reg;
        count_next   = count_reg;
        product_next = product_reg;
        if (cmd.load) begin
            upper_next = '0;
            lower_next = multiplier[WIDTH-1:0];
            booth_next = 1'b0;
            mcand_next = multiplicand[WIDTH-1:0];
            count_next = '0;
        end else if (cmd.step) begin
            upper_next = step_upper;
            lower_next = step_lower;
            booth_next = lower_reg[0];
            count_next = count_reg + CW'(1);
        end
        if (cmd.publish) begin
            product_next = product_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg   <= '0;
            lower_reg   <= '0;
            booth_reg   <= 1'b0;
            mcand_reg   <= '0;
            count_reg   <= '0;
            product_reg <= '0;
        end else begin
            upper_reg   <= upper_next;
            lower_reg   <= lower_next;
            booth_reg   <= booth_next;
            mcand_reg   <= mcand_next;
            count_reg   <= count_next;
            product_reg <= product_next;
        end
    end

    assign status.last_step = (count_reg == CW'(WIDTH - 1));
    assign product          = product_reg;

endmodule

/* rtl/core/br2_ctrl.sv */
// Controller of the radix-2 Booth multiplier: sequences load, step and
// publish commands and owns both handshakes. Depends on br2_pkg.
module br2_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output br2_pkg::br2_cmd_t    cmd,
    input  br2_pkg::br2_status_t status
);
    import br2_pkg::*;

    br2_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // The final step writes the result register, so it waits
                // until that register is free.
                if (!status.last_step) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.step    = 1'b1;
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/core/booth_radix2_multiplier.sv */
// Top level of the sequential radix-2 Booth signed multiplier.
// Instantiates br2_ctrl and br2_datapath; depends on br2_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready, s_multiplier, s_multiplicand) takes one
//   transaction holding two signed operands. Only the low WIDTH bits of each
//   operand are used, read as WIDTH-bit two's complement values.
//   Output channel (m_valid/m_ready, m_product) returns one transaction per
//   input: the signed product, sign-extended to 64 bits.
// Timing:
//   The accepting edge loads the product register; then one Booth step runs
//   per cycle through the single add/subtract unit, WIDTH steps in all, except
//   that the final step waits while a held result is not being taken. The
//   final step writes the result register and raises m_valid at the same edge.
//   A new transaction is taken only once the controller is back in idle after
//   that final step. s_ready is high whenever no multiplication is in progress,
//   even while a finished result waits in the output register.
// Reset:
//   aresetn is synchronous and active low. It returns the controller to idle
//   and drops m_valid; no result is pending afterwards.
// Stalls:
//   If m_ready stays low, the held result and m_valid remain stable. A
//   following multiplication runs up to its final step and then waits there
//   until the output register has been emptied.
module booth_radix2_multiplier #(
    parameter int WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [br2_pkg::OPERAND_W-1:0] s_multiplier,
    input  logic [br2_pkg::OPERAND_W-1:0] s_multiplicand,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [br2_pkg::PRODUCT_W-1:0] m_product
);
    import br2_pkg::*;

    br2_cmd_t    cmd;
    br2_status_t status;

    br2_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    br2_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .multiplier   (s_multiplier),
        .multiplicand (s_multiplicand),
        .product      (m_product)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for booth_radix2_multiplier: a product scoreboard class,
// valid/ready drivers for both channels, idle and stall phases, and a watchdog.
// Depends on br2_pkg and booth_radix2_multiplier.
module tb_top;

    import br2_pkg::*;

    // Operand width that the block is built with. The expected-product
    // computation below follows this value, so it is the only place to change it.
    localparam int MUL_W = 32;

    // The result channel may sit idle for a while without anything being wrong,
    // for example during the long output hold-off. The watchdog limit is several
    // times the worst such stretch.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RESET_CYCLES = 6;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OPERAND_W-1:0] s_multiplier;
    logic [OPERAND_W-1:0] s_multiplicand;
    logic                 m_valid;
    logic                 m_ready;
    logic [PRODUCT_W-1:0] m_product;

    // Scoreboard of expected products. Each accepted operand pair is turned into
    // its product by running the Booth recurrence bit by bit, and the products
    // wait in order until the result channel delivers them.
    class product_scoreboard;
        logic [PRODUCT_W-1:0] expected_products[$];
        int mismatches;
        int products_checked;
        int pairs_noted;

        function new();
            mismatches = 0;
            products_checked = 0;
            pairs_noted = 0;
        endfunction

        // Radix-2 Booth recurrence on a (MUL_W+1)-bit upper half, a MUL_W-bit
        // lower half and the Booth bit. Only the low MUL_W bits of each operand
        // count, and they are read as two's complement.
        function logic [PRODUCT_W-1:0] booth_product(logic [OPERAND_W-1:0] mplier,
                                                     logic [OPERAND_W-1:0] mcand);
            logic [MUL_W:0]          upper;
            logic [MUL_W-1:0]        lower;
            logic [MUL_W:0]          mcand_ext;
            logic                    booth_bit;
            logic                    low_bit;
            logic signed [2*MUL_W:0] whole;
            logic [PRODUCT_W-1:0]    product;
            upper = '0;
            lower = mplier[MUL_W-1:0];
            booth_bit = 1'b0;
            mcand_ext = {mcand[MUL_W-1], mcand[MUL_W-1:0]};
            for (int i = 0; i < MUL_W; i++) begin
                low_bit = lower[0];
                if (!low_bit && booth_bit) begin
                    upper = upper + mcand_ext;
                end else if (low_bit && !booth_bit) begin
                    upper = upper - mcand_ext;
                end
                booth_bit = low_bit;
                lower = {upper[0], lower[MUL_W-1:1]};
                upper = {upper[MUL_W], upper[MUL_W:1]};
            end
            whole = {upper, lower};
            product = PRODUCT_W'(whole);
            return product;
        endfunction

        function void note_operands(logic [OPERAND_W-1:0] mplier,
                                    logic [OPERAND_W-1:0] mcand);
            expected_products.insert(expected_products.size(),
                                     booth_product(mplier, mcand));
            pairs_noted++;
        endfunction

        function void check_product(logic [PRODUCT_W-1:0] actual, time stamp);
            logic [PRODUCT_W-1:0] wanted;
            if (expected_products.size() == 0) begin
                mismatches++;
                $display("%0t: product transaction with none expected: expected none, got %h",
                         stamp, actual);
                return;
            end
            wanted = expected_products.pop_front();
            products_checked++;
            if (actual !== wanted) begin
                mismatches++;
                $display("%0t: product mismatch: expected %h, got %h", stamp, wanted, actual);
            end
        endfunction

        function int pending();
            return expected_products.size();
        endfunction
    endclass

    product_scoreboard products = new();

    // Idle rates in percent, changed by the main sequence between phases.
    int send_idle_pct;
    int recv_stall_pct;
    // Set by the main sequence to ask the receiver for one long hold-off.
    bit hold_off_request;

    booth_radix2_multiplier #(
        .WIDTH(MUL_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_multiplier  (s_multiplier),
        .s_multiplicand(s_multiplicand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_product     (m_product)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one operand pair and return at the edge that accepts it. An optional
    // idle stretch comes first, so gaps land anywhere in the multiplier's busy
    // window. Handshake signals are read right at the edge, before any register
    // updates of that edge, so they are the values the block itself sampled.
    task automatic send_operands(input logic [OPERAND_W-1:0] mplier,
                                 input logic [OPERAND_W-1:0] mcand);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_multiplier <= mplier;
        s_multiplicand <= mcand;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        products.note_operands(mplier, mcand);
    endtask

    // Drop valid and wait until every expected product has been delivered.
    task automatic drain_products();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (products.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Random operands, biased toward the corners of the signed range and small
    // values, where Booth recoding has the most runs and sign changes.
    function automatic logic [OPERAND_W-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4) begin
            return 32'h8000_0000;
        end else if (sel < 8) begin
            return 32'h7fff_ffff;
        end else if (sel < 11) begin
            return 32'hffff_ffff;
        end else if (sel < 14) begin
            return 32'h0000_0000;
        end else if (sel < 17) begin
            return 32'h0000_0001;
        end else if (sel < 35) begin
            return 32'($urandom_range(255)) - 32'd128;
        end
        return $urandom();
    endfunction

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            send_operands(pick_operand(), pick_operand());
        end
        drain_products();
    endtask

    // Result side: check every accepted product, then choose m_ready for the next
    // cycle. A requested hold-off keeps m_ready low for a counted stretch, long
    // enough that the block fills and drops s_ready.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                products.check_product(m_product, $time);
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: counts consecutive cycles without a transaction on either channel.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d products outstanding",
                         $time, quiet_cycles, products.pending());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        // Every input is known from time zero, with reset asserted before any stimulus.
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_multiplier = '0;
        s_multiplicand = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: zero and one, both signs at full scale, the most
        // negative value on each side and on both, and alternating bit patterns
        // that make Booth recoding add or subtract on every step after the first.
        send_operands(32'h0000_0000, 32'h0000_0000);
        send_operands(32'h0000_0001, 32'h0000_0001);
        send_operands(32'hffff_ffff, 32'hffff_ffff);
        send_operands(32'hffff_ffff, 32'h0000_0001);
        send_operands(32'h7fff_ffff, 32'h7fff_ffff);
        send_operands(32'h8000_0000, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'h7fff_ffff);
        send_operands(32'h7fff_ffff, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'h0000_0001);
        send_operands(32'h0000_0001, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'hffff_ffff);
        send_operands(32'hffff_ffff, 32'h8000_0000);
        send_operands(32'haaaa_aaaa, 32'h5555_5555);
        send_operands(32'h5555_5555, 32'haaaa_aaaa);
        send_operands(32'haaaa_aaaa, 32'h8000_0000);
        send_operands(32'h5555_5555, 32'h7fff_ffff);
        send_operands(32'h0000_0000, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'h0000_0000);
        send_operands(32'h0f0f_0f0f, 32'hf0f0_f0f0);
        send_operands(32'h1234_5678, 32'hedcb_a988);
        drain_products();

        // Back-to-back transactions with both sides always ready.
        run_phase(180, 0, 0);

        // Long output hold-off while the sender keeps offering: the block fills
        // and must stall its input without losing or reordering products.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_request = 1'b1;
        repeat (12) begin
            send_operands(pick_operand(), pick_operand());
        end
        drain_products();

        // Sparse sender, then a mostly stalled receiver, then light idling on both.
        run_phase(180, 86, 0);
        run_phase(180, 0, 86);
        run_phase(190, 23, 23);

        // Nothing should come after the last product; none may stay undelivered.
        repeat (2 * MUL_W + 8) @(posedge aclk);
        if (products.pending() != 0) begin
            products.mismatches++;
            $display("%0t: %0d products never delivered: expected %h first, got nothing",
                     $time, products.pending(), products.expected_products[0]);
        end

        $display("Covered %0d operand pairs and %0d checked products: directed corners,",
                 products.pairs_noted, products.products_checked);
        $display("back-to-back, sparse sender, stalled receiver, mixed idling, long hold-off.");
        if (products.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
